/* rtl/core/des_ks_pkg.sv */
`timescale 1ns / 1ps

package des_ks_pkg;

    localparam int KEY_W  = 64;
    localparam int HALF_W = 28;
    localparam int CD_W   = 2 * HALF_W;
    localparam int RK_W   = 48;
    localparam int ROUNDS = 16;
    localparam int RND_W  = $clog2(ROUNDS);
    localparam int KIDX_W = $clog2(KEY_W);
    localparam int CIDX_W = $clog2(CD_W);

    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);

    typedef logic [6:0] t_pos;

    // bit positions, 1 = MSB of the source word
    localparam t_pos PC1_TAB [CD_W] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam t_pos PC2_TAB [RK_W] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,
        7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
        7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,
        7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
        7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
        7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
        7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53,
        7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
    };

    // bit r set: round r rotates by one place, else by two
    localparam logic [ROUNDS-1:0] SHIFT_ONE = 16'h8103;

endpackage

/* rtl/core/des_round_key_schedule.sv */
`timescale 1ns / 1ps
// channel   signals                                   direction
// key       start, busy, i_key_in                     in, start && !busy
// subkey    o_valid, o_subkey, o_round_number,        out, o_last_round a one-cycle strobe
//           o_last_round
//
// A key taken in is loaded into the C and D registers; round 0 then reaches the
// ports through the output registers, then one subkey per cycle, 16 in all,
// one rotate+PC2 pass per cycle. busy drops in the cycle the last round is
// computed, so the next key can follow with no gap on the output. Synchronous
// active-low reset clears the round sequencer and o_valid. The receiver cannot stall.

module des_round_key_schedule
    import des_ks_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KEY_W-1:0]  i_key_in,
    output logic              o_valid,
    output logic [RK_W-1:0]   o_subkey,
    output logic [RND_W-1:0]  o_round_number,
    output logic              o_last_round
);

    logic [HALF_W-1:0] r_c, r_d, n_c, n_d;
    logic [RND_W-1:0]  r_cnt;
    logic              r_active;
    logic              r_valid;
    logic [RK_W-1:0]   r_subkey;
    logic [RND_W-1:0]  r_round_number;
    logic              r_last_round;
    logic [CD_W-1:0]   cd_init;
    logic [RK_W-1:0]   rk;
    logic              accept;
    logic              at_last;

    des_ks_pc1 u_pc1 (
        .i_key (i_key_in),
        .o_cd  (cd_init)
    );

    des_ks_round u_round (
        .i_c         (r_c),
        .i_d         (r_d),
        .i_shift_one (SHIFT_ONE[r_cnt]),
        .o_c         (n_c),
        .o_d         (n_d),
        .o_subkey    (rk)
    );

    assign at_last = (r_cnt == LAST_ROUND);
    assign busy    = r_active && !at_last;
    assign accept  = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (accept) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (r_active) begin
                r_cnt <= r_cnt + 1'b1;
                if (at_last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c <= cd_init[CD_W-1:HALF_W];
            r_d <= cd_init[HALF_W-1:0];
        end else if (r_active) begin
            r_c <= n_c;
            r_d <= n_d;
        end
        r_subkey       <= rk;
        r_round_number <= r_cnt;
        r_last_round   <= at_last;
    end

    assign o_valid        = r_valid;
    assign o_subkey       = r_subkey;
    assign o_round_number = r_round_number;
    assign o_last_round   = r_last_round;

endmodule

/* rtl/core/des_ks_pc1.sv */
`timescale 1ns / 1ps

module des_ks_pc1
    import des_ks_pkg::*;
(
    input  logic [KEY_W-1:0] i_key,
    output logic [CD_W-1:0]  o_cd
);

    always_comb begin
        logic [KIDX_W-1:0] src;
        o_cd = '0;
        for (int i = 0; i < CD_W; i++) begin
            src = KIDX_W'(KEY_W - int'(PC1_TAB[i]));
            o_cd[CD_W-1-i] = i_key[src];
        end
    end

endmodule

/* rtl/core/des_ks_round.sv */
`timescale 1ns / 1ps

module des_ks_round
    import des_ks_pkg::*;
(
    input  logic [HALF_W-1:0] i_c,
    input  logic [HALF_W-1:0] i_d,
    input  logic              i_shift_one,
    output logic [HALF_W-1:0] o_c,
    output logic [HALF_W-1:0] o_d,
    output logic [RK_W-1:0]   o_subkey
);

    logic [CD_W-1:0] cd;

    assign o_c = i_shift_one ? {i_c[HALF_W-2:0], i_c[HALF_W-1]}
                             : {i_c[HALF_W-3:0], i_c[HALF_W-1:HALF_W-2]};
    assign o_d = i_shift_one ? {i_d[HALF_W-2:0], i_d[HALF_W-1]}
                             : {i_d[HALF_W-3:0], i_d[HALF_W-1:HALF_W-2]};
    assign cd  = {o_c, o_d};

    always_comb begin
        logic [CIDX_W-1:0] src;
        o_subkey = '0;
        for (int i = 0; i < RK_W; i++) begin
            src = CIDX_W'(CD_W - int'(PC2_TAB[i]));
            o_subkey[RK_W-1-i] = cd[src];
        end
    end

endmodule
